[sv/pidaw_pkg.sv]
// Package for the PID controller with back-calculation anti-windup.
// Holds widths, register and status codes, the control word layout and
// the microcode table. It depends on nothing else.
package pidaw_pkg;

    localparam int unsigned INTEG_LIMIT_DEF = 80;
    localparam int TS_Q016    = 1376;
    localparam int INV_TS_Q88 = 12190;

    localparam int MEAS_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int DRIVE_W    = 8;
    localparam int SAT_W      = 2;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 48;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;

    localparam logic [LIMIT_W-1:0] CEILING_RESET = 8'd100;

    localparam logic [STEP_W-1:0] ST_FETCH  = 4'd0;
    localparam logic [STEP_W-1:0] ST_PMUL   = 4'd1;
    localparam logic [STEP_W-1:0] ST_IMUL   = 4'd2;
    localparam logic [STEP_W-1:0] ST_TSMUL  = 4'd3;
    localparam logic [STEP_W-1:0] ST_INTEG  = 4'd4;
    localparam logic [STEP_W-1:0] ST_DMUL   = 4'd5;
    localparam logic [STEP_W-1:0] ST_PDSUM  = 4'd6;
    localparam logic [STEP_W-1:0] ST_DECIDE = 4'd7;
    localparam logic [STEP_W-1:0] ST_EMIT   = 4'd8;

    typedef enum logic [1:0] {
        SAT_NONE  = 2'd0,
        SAT_CEIL  = 2'd1,
        SAT_FLOOR = 2'd2
    } sat_code_t;

    typedef enum logic [2:0] {
        M_NONE,
        M_PG_ERR,
        M_IG_ERR,
        M_STEP_TS,
        M_DG_DIFF,
        M_D_INV
    } mul_op_t;

    typedef enum logic [2:0] {
        A_NONE,
        A_FETCH,
        A_SAVEP,
        A_INTEG,
        A_PDSUM,
        A_DECIDE,
        A_BACK
    } alu_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_FETCH,
        J_EMIT
    } jmp_t;

    typedef struct packed {
        mul_op_t             mul_op;
        alu_op_t             alu_op;
        jmp_t                jmp;
        logic [STEP_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        ctrl_t word;
        logic  go;
    } seq_ctl_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [MEAS_W-1:0]        target_level;
        logic [LIMIT_W-1:0]       drive_floor;
        logic [LIMIT_W-1:0]       drive_ceiling;
    } cfg_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{mul_op: M_NONE, alu_op: A_NONE, jmp: J_FETCH, target: ST_FETCH};
        case (step)
            ST_FETCH:  w = '{M_NONE,    A_FETCH,  J_FETCH, ST_FETCH};
            ST_PMUL:   w = '{M_PG_ERR,  A_NONE,   J_NEXT,  ST_FETCH};
            ST_IMUL:   w = '{M_IG_ERR,  A_SAVEP,  J_NEXT,  ST_FETCH};
            ST_TSMUL:  w = '{M_STEP_TS, A_NONE,   J_NEXT,  ST_FETCH};
            ST_INTEG:  w = '{M_DG_DIFF, A_INTEG,  J_NEXT,  ST_FETCH};
            ST_DMUL:   w = '{M_D_INV,   A_NONE,   J_NEXT,  ST_FETCH};
            ST_PDSUM:  w = '{M_NONE,    A_PDSUM,  J_NEXT,  ST_FETCH};
            ST_DECIDE: w = '{M_NONE,    A_DECIDE, J_NEXT,  ST_FETCH};
            ST_EMIT:   w = '{M_NONE,    A_BACK,   J_EMIT,  ST_FETCH};
            default:   w = '{M_NONE,    A_NONE,   J_EMIT,  ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

[sv/pidaw_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on pidaw_pkg for the control word and the microcode table.
module pidaw_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_accept,
    input  logic                s_func,
    input  logic                out_busy,
    output pidaw_pkg::seq_ctl_t ctl,
    output logic                s_ready
);
    import pidaw_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_t             word;
    logic              go;

    always_comb begin
        word      = ucode(step_reg);
        go        = 1'b0;
        step_next = step_reg;
        case (word.jmp)
            J_NEXT: begin
                go        = 1'b1;
                step_next = step_reg + 1'b1;
            end
            J_FETCH: begin
                go = s_accept;
                if (s_accept && !s_func) begin
                    step_next = step_reg + 1'b1;
                end
            end
            J_EMIT: begin
                go = !out_busy;
                if (!out_busy) begin
                    step_next = word.target;
                end
            end
            default: begin
                go        = 1'b0;
                step_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    assign s_ready = (word.jmp == J_FETCH);
    assign ctl     = '{word: word, go: go};

endmodule

[sv/pidaw_datapath.sv]
// Datapath of the PID controller: shared multiplier, integral, limits and
// the output register. Driven by the control word from pidaw_sequencer.
// Depends on pidaw_pkg.
module pidaw_datapath #(
    parameter int unsigned INTEG_LIMIT = pidaw_pkg::INTEG_LIMIT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pidaw_pkg::seq_ctl_t                   ctl,
    input  pidaw_pkg::cfg_t                       cfg,
    input  logic                                  s_func,
    input  logic [pidaw_pkg::MEAS_W-1:0]          s_meas,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [pidaw_pkg::DRIVE_W-1:0]         m_drive,
    output logic [pidaw_pkg::SAT_W-1:0]           m_sat,
    output logic                                  out_busy
);
    import pidaw_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int INT_W = ACC_W + 2;
    localparam int LIM_W = LIMIT_W + FRAC_W;
    localparam logic signed [INT_W-1:0] LIM_POS = INT_W'(INTEG_LIMIT) <<< FRAC_W;
    localparam logic signed [INT_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

    logic signed [MEAS_W-1:0]  err_reg, last_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg, p_reg, pd_reg;
    logic [DRIVE_W-1:0]        drive_reg;
    logic [SAT_W-1:0]          sat_reg;
    logic [LIM_W-1:0]          lim_sel_reg;
    logic                      m_valid_reg;
    logic [DRIVE_W-1:0]        m_drive_reg;
    logic [SAT_W-1:0]          m_sat_reg;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;
    logic signed [ACC_W-1:0]           integ_step;
    logic signed [INT_W-1:0]           integ_sum;
    logic signed [ACC_W-1:0]           integ_clamped;
    logic signed [SUM_W-1:0]           total;
    logic signed [SUM_W-1:0]           hi_lim, lo_lim;
    logic signed [SUM_W-1:0]           back;
    logic signed [ACC_W-1:0]           back_sat;
    logic                              fire;

    assign fire = ctl.go;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.word.mul_op)
            M_PG_ERR: begin
                mul_a = MUL_A_W'(cfg.prop_gain);
                mul_b = MUL_B_W'(err_reg);
            end
            M_IG_ERR: begin
                mul_a = MUL_A_W'(cfg.integ_gain);
                mul_b = MUL_B_W'(err_reg);
            end
            M_STEP_TS: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(TS_Q016);
            end
            M_DG_DIFF: begin
                mul_a = MUL_A_W'(cfg.deriv_gain);
                mul_b = MUL_B_W'(err_reg) - MUL_B_W'(last_reg);
            end
            M_D_INV: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(INV_TS_Q88);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_comb begin
        integ_step = ACC_W'(prod_reg >>> 8);
        integ_sum  = INT_W'(acc_reg) + INT_W'(integ_step);
        if (integ_sum > LIM_POS) begin
            integ_clamped = ACC_W'(LIM_POS);
        end else if (integ_sum < LIM_NEG) begin
            integ_clamped = ACC_W'(LIM_NEG);
        end else begin
            integ_clamped = ACC_W'(integ_sum);
        end
    end

    always_comb begin
        total  = SUM_W'(pd_reg) + SUM_W'(acc_reg);
        hi_lim = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.drive_ceiling, {FRAC_W{1'b0}}});
        lo_lim = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.drive_floor, {FRAC_W{1'b0}}});
        back   = $signed({{(SUM_W-LIM_W){1'b0}}, lim_sel_reg}) - SUM_W'(pd_reg);
        if (back > ACC_MAX) begin
            back_sat = ACC_W'(ACC_MAX);
        end else if (back < ACC_MIN) begin
            back_sat = ACC_W'(ACC_MIN);
        end else begin
            back_sat = ACC_W'(back);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.word.mul_op != M_NONE) begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (fire) begin
            case (ctl.word.alu_op)
                A_FETCH: begin
                    if (!s_func) begin
                        err_reg <= cfg.target_level - s_meas;
                    end
                end
                A_SAVEP: p_reg <= {prod_reg[PROD_W-9:0], 8'b0};
                A_PDSUM: pd_reg <= p_reg + prod_reg;
                A_DECIDE: begin
                    if (total > hi_lim) begin
                        drive_reg   <= cfg.drive_ceiling;
                        sat_reg     <= SAT_CEIL;
                        lim_sel_reg <= {cfg.drive_ceiling, {FRAC_W{1'b0}}};
                    end else if (total < lo_lim) begin
                        drive_reg   <= cfg.drive_floor;
                        sat_reg     <= SAT_FLOOR;
                        lim_sel_reg <= {cfg.drive_floor, {FRAC_W{1'b0}}};
                    end else begin
                        drive_reg   <= total[FRAC_W+DRIVE_W-1:FRAC_W];
                        sat_reg     <= SAT_NONE;
                    end
                end
                A_BACK: begin
                    m_drive_reg <= drive_reg;
                    m_sat_reg   <= sat_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire && (ctl.word.alu_op == A_BACK)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire) begin
                case (ctl.word.alu_op)
                    A_FETCH: begin
                        if (s_func) begin
                            acc_reg  <= '0;
                            last_reg <= '0;
                        end
                    end
                    A_INTEG: acc_reg <= integ_clamped;
                    A_PDSUM: last_reg <= err_reg;
                    A_BACK: begin
                        if (sat_reg != SAT_NONE) begin
                            acc_reg <= back_sat;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_drive  = m_drive_reg;
    assign m_sat    = m_sat_reg;

endmodule

[sv/pid_antiwindup_controller.sv]
// PID controller with back-calculation anti-windup.
// Holds the configuration registers and ties the sequencer to the datapath.
// Depends on pidaw_pkg, pidaw_sequencer and pidaw_datapath.
//
// Usage: configuration writes arrive on cfg_valid/cfg_ready with a register
// index and data; cfg_ready is always high and unknown indexes are dropped.
// Requests enter on the s_ channel: s_tuser is the function flag (compute or
// clear) and s_tdata the measurement. A compute request yields one result
// on the m_ channel, with the drive value in m_tdata and the saturation
// status in m_tuser; a clear request resets the integral and the stored
// error and yields no result.
// A compute request runs a nine-step microprogram that shares one multiplier
// over five products; a new request is accepted only after the last step.
// A clear request is handled within the fetch step itself.
// The result sits in an output register; the next request may be accepted
// while it waits, but the last step stalls until the receiver has taken it.
// Reset clears the integral, the stored error and the step counter, sets
// the gains, setpoint and floor to zero and the ceiling to 100.
module pid_antiwindup_controller #(
    parameter int unsigned INTEG_LIMIT = pidaw_pkg::INTEG_LIMIT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,  // measured[15:0]
    input  logic                                 s_tuser,  // func[0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,  // drive[7:0]
    output logic [1:0]                           m_tuser,  // sat_state[1:0]
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pidaw_pkg::*;

    cfg_t     cfg_reg;
    seq_ctl_t ctl;
    logic     s_accept;
    logic     out_busy;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain     <= '0;
            cfg_reg.integ_gain    <= '0;
            cfg_reg.deriv_gain    <= '0;
            cfg_reg.target_level  <= '0;
            cfg_reg.drive_floor   <= '0;
            cfg_reg.drive_ceiling <= CEILING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_data;
                REG_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg_data;
                REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_data;
                REG_TARGET_LEVEL:  cfg_reg.target_level  <= cfg_data;
                REG_DRIVE_FLOOR:   cfg_reg.drive_floor   <= cfg_data[LIMIT_W-1:0];
                REG_DRIVE_CEILING: cfg_reg.drive_ceiling <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pidaw_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_accept),
        .s_func   (s_tuser),
        .out_busy (out_busy),
        .ctl      (ctl),
        .s_ready  (s_tready)
    );

    pidaw_datapath #(
        .INTEG_LIMIT (INTEG_LIMIT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .s_func   (s_tuser),
        .s_meas   (s_tdata),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_drive  (m_tdata),
        .m_sat    (m_tuser),
        .out_busy (out_busy)
    );

endmodule
